// ===== rtl/srbs_pkg.sv =====
// Shared types, codes and the control store of the sorted range binary search block.
package srbs_pkg;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned STAT_W = 2;
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned PC_W   = 3;

  // Command codes of an input item.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd2;

  // Status codes of a result item.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  // Datapath operation selected by one control word.
  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_ACCEPT  = 3'd1,
    OP_CLEAR   = 3'd2,
    OP_APPEND  = 3'd3,
    OP_LINIT   = 3'd4,
    OP_PROBE   = 3'd5,
    OP_COMPARE = 3'd6,
    OP_EMIT    = 3'd7
  } op_e;

  // Sequencer branch condition.
  typedef enum logic [2:0] {
    C_JUMP     = 3'd0,  // always go to target
    C_DISPATCH = 3'd1,  // on a transfer go to target plus command, else hold
    C_END      = 3'd2,  // go to target when the search interval is empty
    C_MISS     = 3'd3,  // go to target when the probe missed
    C_OUT      = 3'd4   // go to target once the output register is free
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  target;
  } uword_t;

  // Control to the datapath.
  typedef struct packed {
    op_e  op;
    logic in_fire;
  } ctrl_t;

  // Status back to the sequencer.
  typedef struct packed {
    logic search_end;
    logic hit;
    logic out_free;
  } flags_t;

  // Program addresses. The four dispatch targets follow the command codes.
  localparam logic [PC_W-1:0] PC_IDLE    = 3'd0;
  localparam logic [PC_W-1:0] PC_CLEAR   = 3'd1;
  localparam logic [PC_W-1:0] PC_APPEND  = 3'd2;
  localparam logic [PC_W-1:0] PC_LOOKUP  = 3'd3;
  localparam logic [PC_W-1:0] PC_UNUSED  = 3'd4;
  localparam logic [PC_W-1:0] PC_PROBE   = 3'd5;
  localparam logic [PC_W-1:0] PC_COMPARE = 3'd6;
  localparam logic [PC_W-1:0] PC_EMIT    = 3'd7;

  // The microprogram. A word that does not branch falls through to the next address.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{op: OP_NONE, cond: C_JUMP, target: PC_IDLE};
    case (pc)
      PC_IDLE:    w = '{op: OP_ACCEPT,  cond: C_DISPATCH, target: PC_CLEAR};
      PC_CLEAR:   w = '{op: OP_CLEAR,   cond: C_JUMP,     target: PC_EMIT};
      PC_APPEND:  w = '{op: OP_APPEND,  cond: C_JUMP,     target: PC_EMIT};
      PC_LOOKUP:  w = '{op: OP_LINIT,   cond: C_JUMP,     target: PC_PROBE};
      PC_UNUSED:  w = '{op: OP_NONE,    cond: C_JUMP,     target: PC_EMIT};
      PC_PROBE:   w = '{op: OP_PROBE,   cond: C_END,      target: PC_EMIT};
      PC_COMPARE: w = '{op: OP_COMPARE, cond: C_MISS,     target: PC_PROBE};
      PC_EMIT:    w = '{op: OP_EMIT,    cond: C_OUT,      target: PC_IDLE};
      default:    w = '{op: OP_NONE,    cond: C_JUMP,     target: PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/srbs_if.sv =====
// Valid/ready channel interfaces for the request and response sides.
interface srbs_req_if import srbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

interface srbs_rsp_if import srbs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [IDX_W-1:0]  entry_index;

  modport source (output valid, output status, output entry_index, input ready);
  modport sink   (input valid, input status, input entry_index, output ready);
endinterface

// ===== rtl/sorted_range_binary_search.sv =====
// Top level of the sorted range binary search block.
// The block keeps a table of up to TABLE_DEPTH start addresses, appended one per request
// in ascending order after a clear; the user must keep that order, as the block does not
// enforce it. Lookups are answered by binary search: an address hits entry i when it is at
// least that entry's start and below the next entry's start, and the last entry runs up to,
// but not including, the all-ones address. Each request gives exactly one response with a
// status (done or hit, not found, or table full on append) and the hit index. A small
// microprogram drives the work one request at a time: a clear, an append or an unused
// command does its operation and goes on to the response; a lookup sets up the search
// interval and then repeats a probe and a compare until a hit or an empty interval, with P
// probes, where P is at most ceil(log2(entries + 1)). Each probe reads the start memory
// with registered data at the probed entry and its successor before the two compares.
// A finished response sits in an output register, so the next request is taken while it
// waits on the response channel.
module sorted_range_binary_search import srbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  srbs_req_if.sink     req_i,
  srbs_rsp_if.source   rsp_o
);

  ctrl_t  ctrl;
  flags_t flags;

  // The sequencer steps through the control store and steers the datapath.
  srbs_useq u_useq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .command_i  (req_i.command),
    .flags_i    (flags),
    .in_ready_o (req_i.ready),
    .ctrl_o     (ctrl)
  );

  // The datapath holds the table, the search interval and the response register.
  srbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .command_i     (req_i.command),
    .address_i     (req_i.address),
    .out_ready_i   (rsp_o.ready),
    .out_valid_o   (rsp_o.valid),
    .status_o      (rsp_o.status),
    .entry_index_o (rsp_o.entry_index),
    .flags_o       (flags)
  );

endmodule

// ===== rtl/srbs_useq.sv =====
// Microcode sequencer: step counter, control store and branch logic.
module srbs_useq import srbs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [CMD_W-1:0] command_i,
  input  flags_t           flags_i,
  output logic             in_ready_o,
  output ctrl_t            ctrl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          word;

  assign word       = ucode_rom(pc_q);
  assign in_ready_o = (word.op == OP_ACCEPT);
  assign ctrl_o.op      = word.op;
  assign ctrl_o.in_fire = (word.op == OP_ACCEPT) && in_valid_i;

  always_comb begin
    pc_d = pc_q + PC_W'(1);
    case (word.cond)
      C_JUMP:     pc_d = word.target;
      C_DISPATCH: pc_d = in_valid_i ? word.target + PC_W'(command_i) : pc_q;
      C_END:      if (flags_i.search_end) pc_d = word.target;
      C_MISS:     if (!flags_i.hit) pc_d = word.target;
      C_OUT:      pc_d = flags_i.out_free ? word.target : pc_q;
      default:    pc_d = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== rtl/srbs_datapath.sv =====
// Datapath: start address memory, search bounds, probe compare and output register.
module srbs_datapath import srbs_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [ADDR_W-1:0] address_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [IDX_W-1:0]  entry_index_o,
  output flags_t            flags_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [ADDR_W-1:0] mem_q [TABLE_DEPTH];

  logic [CW-1:0]     count_q;
  logic [CW-1:0]     lo_q;
  logic [CW-1:0]     hi_excl_q;
  logic [IW-1:0]     mid_q;
  logic [ADDR_W-1:0] addr_q;
  logic [ADDR_W-1:0] rd_lo_q;
  logic [ADDR_W-1:0] rd_hi_q;
  logic [STAT_W-1:0] stat_q;
  logic [IDX_W-1:0]  idx_q;
  logic              out_v_q;
  logic [STAT_W-1:0] out_stat_q;
  logic [IDX_W-1:0]  out_idx_q;

  logic              full;
  logic [CW:0]       mid_sum;
  logic [IW-1:0]     mid;
  logic [CW-1:0]     mid_ext;
  logic [CW-1:0]     mid_next;
  logic [IW-1:0]     mid_next_idx;
  logic [ADDR_W-1:0] upper;
  logic              hit;
  logic [IW+IDX_W-1:0] idx_wide;
  logic              out_free;

  assign full         = (count_q == CW'(TABLE_DEPTH));
  // Midpoint of the half-open interval [lo, hi_excl).
  assign mid_sum      = {1'b0, lo_q} + {1'b0, hi_excl_q} - (CW+1)'(1);
  assign mid          = mid_sum[IW:1];
  assign mid_ext      = CW'(mid_q);
  assign mid_next     = mid_ext + CW'(1);
  assign mid_next_idx = IW'(mid + IW'(1));
  // The last valid entry reaches up to, but not including, all ones.
  assign upper        = (mid_next < count_q) ? rd_hi_q : '1;
  assign hit          = (addr_q >= rd_lo_q) && (addr_q < upper);
  assign idx_wide     = {{IDX_W{1'b0}}, mid_q};
  assign out_free     = !out_v_q || out_ready_i;

  assign flags_o.search_end = (lo_q >= hi_excl_q);
  assign flags_o.hit        = hit;
  assign flags_o.out_free   = out_free;

  assign out_valid_o   = out_v_q;
  assign status_o      = out_stat_q;
  assign entry_index_o = out_idx_q;

  // Table storage: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_APPEND && !full) begin
      mem_q[count_q[IW-1:0]] <= addr_q;
    end
    if (ctrl_i.op == OP_PROBE) begin
      rd_lo_q <= mem_q[mid];
      rd_hi_q <= mem_q[mid_next_idx];
      mid_q   <= mid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_fire) begin
      addr_q <= address_i;
      stat_q <= ST_OK;
      idx_q  <= '0;
    end
    case (ctrl_i.op)
      OP_APPEND: if (full) stat_q <= ST_FULL;
      OP_LINIT: begin
        lo_q      <= '0;
        hi_excl_q <= count_q;
        stat_q    <= ST_MISS;
      end
      OP_COMPARE: begin
        if (hit) begin
          stat_q <= ST_OK;
          idx_q  <= idx_wide[IDX_W-1:0];
        end else if (rd_lo_q < addr_q) begin
          lo_q <= mid_next;
        end else begin
          hi_excl_q <= mid_ext;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      case (ctrl_i.op)
        OP_CLEAR:  count_q <= '0;
        OP_APPEND: if (!full) count_q <= count_q + CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (ctrl_i.op == OP_EMIT && out_free) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.op == OP_EMIT && out_free) begin
      out_stat_q <= stat_q;
      out_idx_q  <= idx_q;
    end
  end

  // The command is consumed by the sequencer's dispatch; it is kept here only for checking.
  logic [CMD_W-1:0] cmd_q;
  always_ff @(posedge clk_i) begin
    if (ctrl_i.in_fire) cmd_q <= command_i;
  end

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_probe_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_COMPARE) |-> (hi_excl_q <= count_q) && (lo_q < hi_excl_q)
      && (cmd_q == CMD_LOOKUP))
    else $error("probe outside the valid entries");

  a_full_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_APPEND && full) |=> $stable(count_q) && (stat_q == ST_FULL))
    else $error("append to a full table changed the count");
`endif

endmodule
